// File: rtl/dictionary_segmentation_check_top_defines.svh
// Assertion macros used by the top RTL file of the dictionary segmentation checker.
`ifndef DICTIONARY_SEGMENTATION_CHECK_TOP_DEFINES_SVH
`define DICTIONARY_SEGMENTATION_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define DSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define DSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dsc_pkg.sv
`default_nettype none
package dsc_pkg;

  // Dictionary geometry
  localparam int PAT_SLOTS   = 512;
  localparam int MAX_PAT_LEN = 8;
  localparam int CELLS       = 8;
  localparam int ROWS        = PAT_SLOTS / CELLS;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int TOTAL_W     = $clog2(PAT_SLOTS + 1);
  localparam int LEN_W       = $clog2(MAX_PAT_LEN + 1);
  localparam int TEXT_W      = MAX_PAT_LEN * 8;
  localparam int REACH_W     = MAX_PAT_LEN + 1;
  localparam int CNT_W       = 16;
  localparam int OUT_W       = 24;

  // Input word kinds (tuser)
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_PAT    = 2'd1;
  localparam logic [1:0] FUNC_DESIGN = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             hit;
  } link_t;

  // Dictionary write from the loader
  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] col;
    logic [LEN_W-1:0]  len;
    logic [TEXT_W-1:0] text;
  } wr_t;

  // Search key broadcast to all cells
  typedef struct packed {
    logic [TEXT_W-1:0]  recent;
    logic [REACH_W-1:0] reach;
  } key_t;

  // A stored pattern matches when its bytes equal the newest design bytes
  // and the prefix end just before it was reachable.
  function automatic logic entry_match(input logic [TEXT_W-1:0] text,
                                       input logic [LEN_W-1:0] len,
                                       input key_t key);
    logic ok;
    ok = (len != '0) && key.reach[len - LEN_W'(1)];
    for (int b = 0; b < MAX_PAT_LEN; b++) begin
      if ((LEN_W'(b) < len) && (key.recent[8*b +: 8] != text[8*b +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

// File: rtl/dsc_cell.sv
`default_nettype none
module dsc_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [dsc_pkg::CELL_W-1:0]  cell_id,
  input  wire  [dsc_pkg::TOTAL_W-1:0] total,
  input  wire  dsc_pkg::key_t         key,
  input  wire  dsc_pkg::wr_t          wr,
  input  wire  dsc_pkg::link_t        link_in,
  output dsc_pkg::link_t              link_out
);
  import dsc_pkg::*;

  // one row per slot group: length on top, text below
  logic [LEN_W+TEXT_W-1:0] mem [ROWS];
  logic [LEN_W+TEXT_W-1:0] rd_r;
  logic                    valid_r;
  logic [ROW_W-1:0]        row_r;
  logic                    hit_r;
  logic                    live;
  logic                    match;

  // dictionary store, registered read at the incoming row
  always_ff @(posedge clk) begin
    if (wr.en && (wr.col == cell_id)) begin
      mem[wr.row] <= {wr.len, wr.text};
    end
    rd_r <= mem[link_in.row];
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= link_in.row;
    hit_r <= link_in.hit;
  end

  // slot number is row then cell; only slots below the fill count are live
  assign live  = (TOTAL_W'({row_r, cell_id}) < total);
  assign match = entry_match(rd_r[TEXT_W-1:0], rd_r[LEN_W+TEXT_W-1:TEXT_W], key);

  always_comb begin
    link_out.valid = valid_r;
    link_out.row   = row_r;
    link_out.hit   = hit_r | (valid_r & live & match);
  end

endmodule
`default_nettype wire

// File: rtl/dsc_loader.sv
`default_nettype none
module dsc_loader (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         clr,
  input  wire                         pat_en,
  input  wire  [7:0]                  sym,
  input  wire                         last,
  output dsc_pkg::wr_t                wr,
  output logic [dsc_pkg::TOTAL_W-1:0] total,
  output logic                        overflow
);
  import dsc_pkg::*;

  logic [TEXT_W-1:0]  build_text_r, build_text_nxt;
  logic [LEN_W-1:0]   build_len_r, build_len_nxt;
  logic               too_long_r, too_long_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               overflow_r, overflow_nxt;
  logic               store;

  // pattern assembly and slot allocation
  always_comb begin
    build_text_nxt = build_text_r;
    build_len_nxt  = build_len_r;
    too_long_nxt   = too_long_r;
    total_nxt      = total_r;
    overflow_nxt   = overflow_r;
    store          = 1'b0;
    if (clr) begin
      build_text_nxt = '0;
      build_len_nxt  = '0;
      too_long_nxt   = 1'b0;
      total_nxt      = '0;
      overflow_nxt   = 1'b0;
    end else if (pat_en) begin
      if (build_len_r < LEN_W'(MAX_PAT_LEN)) begin
        build_text_nxt = (build_text_r << 8) | TEXT_W'(sym);
        build_len_nxt  = build_len_r + LEN_W'(1);
      end else begin
        too_long_nxt = 1'b1;
      end
      if (last) begin
        if (too_long_nxt || (total_r >= TOTAL_W'(PAT_SLOTS))) begin
          overflow_nxt = 1'b1;
        end else begin
          store     = 1'b1;
          total_nxt = total_r + TOTAL_W'(1);
        end
      end
    end
  end

  always_comb begin
    wr.en   = store;
    wr.row  = total_r[ROW_W+CELL_W-1:CELL_W];
    wr.col  = total_r[CELL_W-1:0];
    wr.len  = build_len_nxt;
    wr.text = build_text_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      build_text_r <= '0;
      build_len_r  <= '0;
      too_long_r   <= 1'b0;
      total_r      <= '0;
      overflow_r   <= 1'b0;
    end else if (pat_en && last && !clr) begin
      // pattern closed: start a fresh one
      build_text_r <= '0;
      build_len_r  <= '0;
      too_long_r   <= 1'b0;
      total_r      <= total_nxt;
      overflow_r   <= overflow_nxt;
    end else begin
      build_text_r <= build_text_nxt;
      build_len_r  <= build_len_nxt;
      too_long_r   <= too_long_nxt;
      total_r      <= total_nxt;
      overflow_r   <= overflow_nxt;
    end
  end

  assign total    = total_r;
  assign overflow = overflow_r;

endmodule
`default_nettype wire

// File: rtl/dictionary_segmentation_check_top.sv
`default_nettype none
// Channel   Direction  tdata                                    tuser       tlast
// in_       slave      [7:0] symbol                             [1:0] func  last
// out_      master     [0] possible, [16:1] count, [17] ovfl    -           -
//
// A design word sweeps the stored dictionary through a chain of 8 cells, one row
// of 8 slots entering per cycle, then waits for the chain to drain; with an
// empty dictionary the sweep is skipped.
// Reset (rst_n, synchronous) empties the dictionary; no clearing pass is needed.
// A stalled result is held in the output register; a new design word is taken
// meanwhile, and its own verdict waits until the held result is accepted.
module dictionary_segmentation_check_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] symbol
  input  wire  [1:0]  in_tuser,   // [1:0] func
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // [0] possible, [16:1] possible_count,
                                  // [17] dictionary_overflow, [23:18] zero
);
  import dsc_pkg::*;

  state_t             state_r, state_nxt;
  logic [TEXT_W-1:0]  recent_r;
  logic [REACH_W-1:0] reach_r;
  logic               last_r;
  logic [ROW_W-1:0]   row_r;
  logic               hit_acc_r;
  logic [CNT_W-1:0]   success_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic               in_acc;
  logic               clr;
  logic               pat_en;
  logic               design_en;
  logic               finish;
  logic               hit_now;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_m1;
  logic [ROW_W-1:0]   last_row;
  logic               overflow;
  logic [CNT_W-1:0]   success_inc;
  wr_t                wr;
  key_t               key;
  link_t              head_link;
  link_t              chain [CELLS+1];

  assign in_acc    = in_tvalid & in_tready;
  assign clr       = in_acc & (in_tuser == FUNC_CLEAR);
  assign pat_en    = in_acc & (in_tuser == FUNC_PAT);
  assign design_en = in_acc & (in_tuser == FUNC_DESIGN);

  assign total_m1 = total - TOTAL_W'(1);
  assign last_row = total_m1[ROW_W+CELL_W-1:CELL_W];

  // pattern loading
  dsc_loader u_loader (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .pat_en   (pat_en),
    .sym      (in_tdata),
    .last     (in_tlast),
    .wr       (wr),
    .total    (total),
    .overflow (overflow)
  );

  // row of match cells
  assign key.recent = recent_r;
  assign key.reach  = reach_r;
  assign chain[0]   = head_link;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    dsc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (CELL_W'(k)),
      .total    (total),
      .key      (key),
      .wr       (wr),
      .link_in  (chain[k]),
      .link_out (chain[k+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (design_en) begin
          state_nxt = (total == '0) ? S_DONE : S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (row_r == last_row) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (chain[CELLS].valid && (chain[CELLS].row == last_row)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_tready       = 1'b0;
    head_link.valid = 1'b0;
    head_link.row   = row_r;
    head_link.hit   = 1'b0;
    finish          = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_SWEEP: head_link.valid = 1'b1;
      S_DRAIN: ;
      S_DONE:  finish = !last_r || !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign hit_now     = hit_acc_r;
  assign success_inc = (hit_now && (success_r != '1)) ? success_r + CNT_W'(1) : success_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      recent_r  <= '0;
      reach_r   <= REACH_W'(1);
      success_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        recent_r  <= '0;
        reach_r   <= REACH_W'(1);
        success_r <= '0;
      end else if (design_en) begin
        recent_r <= (recent_r << 8) | TEXT_W'(in_tdata);
      end else if (finish) begin
        if (last_r) begin
          recent_r  <= '0;
          reach_r   <= REACH_W'(1);
          success_r <= success_inc;
        end else begin
          reach_r <= {reach_r[REACH_W-2:0], hit_now};
        end
      end
    end
  end

  // sweep row counter and verdict collection
  always_ff @(posedge clk) begin
    if (design_en) begin
      last_r    <= in_tlast;
      row_r     <= '0;
      hit_acc_r <= 1'b0;
    end else begin
      if (state_r == S_SWEEP) begin
        row_r <= row_r + ROW_W'(1);
      end
      if (chain[CELLS].valid) begin
        hit_acc_r <= hit_acc_r | chain[CELLS].hit;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && last_r) begin
      out_data_r <= {6'd0, overflow, success_inc, hit_now};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `include "dictionary_segmentation_check_top_defines.svh"

  `DSC_ASSERT_NOW(a_chain_row_range, clk, rst_n, chain[CELLS].valid, chain[CELLS].row <= last_row, "chain returned a row past the last used row")
  `DSC_ASSERT_NOW(a_chain_idle, clk, rst_n, state_r == S_IDLE, !chain[CELLS].valid, "chain still busy while controller idle")
  `DSC_ASSERT_NEXT(a_count_mono, clk, rst_n, rst_n && !clr, success_r >= $past(success_r), "success count went down without a clear")

endmodule
`default_nettype wire
